### design/pprk_pkg.sv
`default_nettype none
package pprk_pkg;

  typedef logic signed [31:0] word_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } opcode_e;

  // Coefficient table layout
  localparam int unsigned SLOT_K     = 0;
  localparam int unsigned SLOT_FX    = 0;
  localparam int unsigned SLOT_U0    = 2;
  localparam int unsigned SLOT_FY    = 4;
  localparam int unsigned SLOT_V0    = 5;
  localparam int unsigned SLOT_R     = 9;
  localparam int unsigned SLOT_T     = 18;
  localparam int unsigned SLOT_K1    = 21;
  localparam int unsigned SLOTS_USED = 22;

  // Clamp a wide signed value to a signed 32-bit word.
  function automatic word_t sat32(input logic signed [65:0] x);
    word_t r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/pprk_div.sv
`default_nettype none
// Two-lane pipelined signed divider: quo = sat32(num * 2^FRAC_BITS / den),
// truncating toward zero. One quotient bit per stage, FRAC_BITS+32 stages.
module pprk_div #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SIDE_W    = 1
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  wire pprk_pkg::word_t         num_a_i,
  input  wire pprk_pkg::word_t         den_a_i,
  input  wire pprk_pkg::word_t         num_b_i,
  input  wire pprk_pkg::word_t         den_b_i,
  input  wire [SIDE_W-1:0]             side_i,
  output logic                         valid_o,
  output pprk_pkg::word_t              quo_a_o,
  output pprk_pkg::word_t              quo_b_o,
  output logic [SIDE_W-1:0]            side_o,
  output logic                         busy_o
);

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam logic [NW-1:0] LIM_POS = NW'(64'd2147483647);
  localparam logic [NW-1:0] LIM_NEG = NW'(64'd2147483648);

  logic              v_q     [NW];
  logic [31:0]       rem_a_q [NW];
  logic [NW-1:0]     n_a_q   [NW];
  logic [31:0]       d_a_q   [NW];
  logic              neg_a_q [NW];
  logic [31:0]       rem_b_q [NW];
  logic [NW-1:0]     n_b_q   [NW];
  logic [31:0]       d_b_q   [NW];
  logic              neg_b_q [NW];
  logic [SIDE_W-1:0] side_q  [NW];
  logic [NW-1:0]     v_flat;

  // One restoring step: shift in a dividend bit, subtract if it fits.
  function automatic logic [32+NW-1:0] div_step(input logic [31:0] rem,
                                                input logic [NW-1:0] n,
                                                input logic [31:0] d);
    logic [32:0] sh;
    logic [32:0] diff;
    logic        qb;
    sh   = {rem, n[NW-1]};
    diff = sh - {1'b0, d};
    qb   = (sh >= {1'b0, d});
    return {(qb ? diff[31:0] : sh[31:0]), n[NW-2:0], qb};
  endfunction

  function automatic logic [31:0] mag(input pprk_pkg::word_t x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic pprk_pkg::word_t fin(input logic [NW-1:0] q, input logic neg);
    pprk_pkg::word_t r;
    if (neg) begin
      r = (q > LIM_NEG) ? 32'sh80000000 : -q[31:0];
    end else begin
      r = (q > LIM_POS) ? 32'sh7fffffff : q[31:0];
    end
    return r;
  endfunction

  for (genvar g = 0; g < NW; g++) begin : g_stage
    if (g == 0) begin : g_first
      // Load the magnitudes and run the first step
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else if (en_i) begin
          v_q[g] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          {rem_a_q[g], n_a_q[g]} <= div_step(32'd0, {mag(num_a_i), FRAC_BITS'(0)},
                                             mag(den_a_i));
          {rem_b_q[g], n_b_q[g]} <= div_step(32'd0, {mag(num_b_i), FRAC_BITS'(0)},
                                             mag(den_b_i));
          d_a_q[g]   <= mag(den_a_i);
          d_b_q[g]   <= mag(den_b_i);
          neg_a_q[g] <= num_a_i[31] ^ den_a_i[31];
          neg_b_q[g] <= num_b_i[31] ^ den_b_i[31];
          side_q[g]  <= side_i;
        end
      end
    end else begin : g_next
      // Advance one quotient bit
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else if (en_i) begin
          v_q[g] <= v_q[g-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          {rem_a_q[g], n_a_q[g]} <= div_step(rem_a_q[g-1], n_a_q[g-1], d_a_q[g-1]);
          {rem_b_q[g], n_b_q[g]} <= div_step(rem_b_q[g-1], n_b_q[g-1], d_b_q[g-1]);
          d_a_q[g]   <= d_a_q[g-1];
          d_b_q[g]   <= d_b_q[g-1];
          neg_a_q[g] <= neg_a_q[g-1];
          neg_b_q[g] <= neg_b_q[g-1];
          side_q[g]  <= side_q[g-1];
        end
      end
    end
    assign v_flat[g] = v_q[g];
  end

  // Sign and clamp the final quotients
  assign valid_o = v_q[NW-1];
  assign quo_a_o = fin(n_a_q[NW-1], neg_a_q[NW-1]);
  assign quo_b_o = fin(n_b_q[NW-1], neg_b_q[NW-1]);
  assign side_o  = side_q[NW-1];
  assign busy_o  = |v_flat;

endmodule
`default_nettype wire

### design/pinhole_projection_radial_k1.sv
`default_nettype none
// Pinhole projection with one radial distortion term.
// Input channel (in_valid_i / in_stall_o): opcode_i = load writes coef_value_i
// into table slot coef_index_i (0-8 K, 9-17 R, 18-20 t, 21 k1) and gives no
// result; opcode_i = point projects (point_x_i, point_y_i, point_z_i) and
// gives exactly one result on the output channel (out_valid_o / out_stall_i):
// image_u_o, image_v_o and divide_fault_o (set, with zero image, when depth,
// fx or fy is zero). A transfer happens when valid is high and stall is low.
// Throughput: one point per cycle while the output is not stalled; the
// two dividers each produce one quotient bit per stage.
// A load waits in stall until every point in flight has left the output
// register, so in-flight points always see the table they entered with.
// When the receiver stalls a waiting result, the whole pipeline holds and the
// input stalls; nothing is lost or repeated.
// Reset empties the pipeline; table contents are undefined until written.
module pinhole_projection_radial_k1 #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire                  opcode_i,
  input  wire [4:0]            coef_index_i,
  input  wire pprk_pkg::word_t coef_value_i,
  input  wire pprk_pkg::word_t point_x_i,
  input  wire pprk_pkg::word_t point_y_i,
  input  wire pprk_pkg::word_t point_z_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output pprk_pkg::word_t      image_u_o,
  output pprk_pkg::word_t      image_v_o,
  output logic                 divide_fault_o
);

  localparam int unsigned SIDE_B = 1 + 4 * 32;

  logic en, busy, in_acc, dva_v, dvb_v, dva_busy, dvb_busy;
  pprk_pkg::word_t coef_q [pprk_pkg::SLOTS_USED];
  pprk_pkg::word_t pt [3];

  // Shift a product right by FRAC_BITS (floor) into a wide sum operand.
  function automatic logic signed [65:0] shr(input logic signed [63:0] p);
    return 66'(p >>> FRAC_BITS);
  endfunction

  assign en     = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en ||
                      (in_valid_i && (opcode_i == pprk_pkg::OP_LOAD) && busy);
  assign in_acc = in_valid_i && !in_stall_o;
  assign pt[0]  = point_x_i;
  assign pt[1]  = point_y_i;
  assign pt[2]  = point_z_i;

  // Write coefficients; slots past the depth or past slot 21 are dropped
  always_ff @(posedge clk_i) begin
    if (in_acc && (opcode_i == pprk_pkg::OP_LOAD) &&
        ({27'd0, coef_index_i} < TABLE_DEPTH) &&
        ({27'd0, coef_index_i} < pprk_pkg::SLOTS_USED)) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // Stage 1: R * X products
  logic                   s1_v_q;
  logic signed [63:0]     pr_q [3][3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_acc && (opcode_i == pprk_pkg::OP_POINT);
    end
  end
  for (genvar i = 0; i < 3; i++) begin : g_pr
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en) begin
          pr_q[i][j] <= coef_q[pprk_pkg::SLOT_R + 3 * i + j] * pt[j];
        end
      end
    end
  end

  // Stage 2: camera coordinates c = R*X + t
  logic                   s2_v_q;
  pprk_pkg::word_t        c_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end
  for (genvar i = 0; i < 3; i++) begin : g_c
    always_ff @(posedge clk_i) begin
      if (en) begin
        c_q[i] <= pprk_pkg::sat32(shr(pr_q[i][0]) + shr(pr_q[i][1]) + shr(pr_q[i][2]) +
                                  66'(coef_q[pprk_pkg::SLOT_T + i]));
      end
    end
  end

  // Stage 3: K * c products
  logic                   s3_v_q;
  logic signed [63:0]     pk_q [3][3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end
  for (genvar i = 0; i < 3; i++) begin : g_pk
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en) begin
          pk_q[i][j] <= coef_q[pprk_pkg::SLOT_K + 3 * i + j] * c_q[j];
        end
      end
    end
  end

  // Stage 4: homogeneous pixel p = K*c and the zero-divisor check
  logic                   s4_v_q, s4_fault_q;
  pprk_pkg::word_t        p_q [3];
  pprk_pkg::word_t        p_d [3];
  for (genvar i = 0; i < 3; i++) begin : g_p
    assign p_d[i] = pprk_pkg::sat32(shr(pk_q[i][0]) + shr(pk_q[i][1]) + shr(pk_q[i][2]));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0]     <= p_d[0];
      p_q[1]     <= p_d[1];
      p_q[2]     <= p_d[2];
      s4_fault_q <= (p_d[2] == 32'sd0) || (coef_q[pprk_pkg::SLOT_FX] == 32'sd0) ||
                    (coef_q[pprk_pkg::SLOT_FY] == 32'sd0);
    end
  end

  // Divide by depth
  pprk_pkg::word_t dva_u, dva_v_w;
  logic            dva_fault;
  pprk_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_depth (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .num_a_i (p_q[0]),
    .den_a_i (p_q[2]),
    .num_b_i (p_q[1]),
    .den_b_i (p_q[2]),
    .side_i  (s4_fault_q),
    .valid_o (dva_v),
    .quo_a_o (dva_u),
    .quo_b_o (dva_v_w),
    .side_o  (dva_fault),
    .busy_o  (dva_busy)
  );

  // Stage 5: offset from the principal point
  logic            s5_v_q, s5_fault_q;
  pprk_pkg::word_t u5_q, v5_q, du0_q, dv0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= dva_v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      u5_q       <= dva_u;
      v5_q       <= dva_v_w;
      du0_q      <= pprk_pkg::sat32(66'(dva_u) - 66'(coef_q[pprk_pkg::SLOT_U0]));
      dv0_q      <= pprk_pkg::sat32(66'(dva_v_w) - 66'(coef_q[pprk_pkg::SLOT_V0]));
      s5_fault_q <= dva_fault;
    end
  end

  // Normalize by the focal lengths
  pprk_pkg::word_t   nx, ny;
  logic [SIDE_B-1:0] side_b;
  pprk_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_B)) u_div_focal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_v_q),
    .num_a_i (du0_q),
    .den_a_i (coef_q[pprk_pkg::SLOT_FX]),
    .num_b_i (dv0_q),
    .den_b_i (coef_q[pprk_pkg::SLOT_FY]),
    .side_i  ({s5_fault_q, u5_q, v5_q, du0_q, dv0_q}),
    .valid_o (dvb_v),
    .quo_a_o (nx),
    .quo_b_o (ny),
    .side_o  (side_b),
    .busy_o  (dvb_busy)
  );

  // Stage 6: squares and k1 products
  logic               s6_v_q, s6_fault_q;
  pprk_pkg::word_t    u6_q, v6_q;
  logic signed [63:0] xx_q, yy_q, pu_q, pv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= dvb_v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q       <= nx * nx;
      yy_q       <= ny * ny;
      pu_q       <= $signed(side_b[63:32]) * coef_q[pprk_pkg::SLOT_K1];
      pv_q       <= $signed(side_b[31:0]) * coef_q[pprk_pkg::SLOT_K1];
      u6_q       <= side_b[127:96];
      v6_q       <= side_b[95:64];
      s6_fault_q <= side_b[128];
    end
  end

  // Stage 7: r^2 and scaled k1 terms
  logic            s7_v_q, s7_fault_q;
  pprk_pkg::word_t u7_q, v7_q, su_q, sv_q, r2_q;
  logic [64:0]     sq;
  logic [64:0]     sq_sh;
  assign sq    = {1'b0, xx_q} + {1'b0, yy_q};
  assign sq_sh = sq >> FRAC_BITS;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= s6_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q       <= (sq_sh > 65'd2147483647) ? 32'sh7fffffff : sq_sh[31:0];
      su_q       <= pprk_pkg::sat32(shr(pu_q));
      sv_q       <= pprk_pkg::sat32(shr(pv_q));
      u7_q       <= u6_q;
      v7_q       <= v6_q;
      s7_fault_q <= s6_fault_q;
    end
  end

  // Stage 8: distortion products
  logic               s8_v_q, s8_fault_q;
  pprk_pkg::word_t    u8_q, v8_q;
  logic signed [63:0] mu_q, mv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (en) begin
      s8_v_q <= s7_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_q       <= su_q * r2_q;
      mv_q       <= sv_q * r2_q;
      u8_q       <= u7_q;
      v8_q       <= v7_q;
      s8_fault_q <= s7_fault_q;
    end
  end

  // Stage 9: distortion offsets
  logic            s9_v_q, s9_fault_q;
  pprk_pkg::word_t u9_q, v9_q, du_q, dv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_v_q <= 1'b0;
    end else if (en) begin
      s9_v_q <= s8_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      du_q       <= pprk_pkg::sat32(shr(mu_q));
      dv_q       <= pprk_pkg::sat32(shr(mv_q));
      u9_q       <= u8_q;
      v9_q       <= v8_q;
      s9_fault_q <= s8_fault_q;
    end
  end

  // Output register: add the offsets, zero the image on a fault
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= s9_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      image_u_o      <= s9_fault_q ? 32'sd0 : pprk_pkg::sat32(66'(u9_q) + 66'(du_q));
      image_v_o      <= s9_fault_q ? 32'sd0 : pprk_pkg::sat32(66'(v9_q) + 66'(dv_q));
      divide_fault_o <= s9_fault_q;
    end
  end

  assign busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q || dva_busy || s5_v_q ||
                dvb_busy || s6_v_q || s7_v_q || s8_v_q || s9_v_q || out_valid_o;

  // A load never overlaps points in flight
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (opcode_i == pprk_pkg::OP_LOAD)) |-> !busy)
    else $error("load accepted while points in flight");

  // A faulted result carries a zero image
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_fault_o) |-> (image_u_o == 32'sd0 && image_v_o == 32'sd0))
    else $error("fault with nonzero image");

  // An accepted point enters the first stage
  a_point_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (opcode_i == pprk_pkg::OP_POINT)) |=> s1_v_q)
    else $error("accepted point lost at entry");

  // A held output freezes the stage behind it
  a_hold_s9: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && s9_v_q) |=> (s9_v_q && $stable(u9_q)))
    else $error("stage moved under stall");

endmodule
`default_nettype wire
